// ===== hw/rtl/scpa_pkg.sv =====
// Shared types, register map and status codes for the size class pool allocator.
// No dependencies; every allocator file imports this package.
package scpa_pkg;

	// Pool geometry.
	localparam int NUM_CLASSES = 4;
	localparam int MAX_SLOTS   = 64;

	// Field widths.
	localparam int BYTES_W  = 17;
	localparam int COUNT_W  = 7;
	localparam int REQ_W    = 20;
	localparam int CLASS_W  = 2;
	localparam int SLOT_W   = 6;
	localparam int OFFSET_W = 24;
	localparam int STATUS_W = 3;

	typedef logic [BYTES_W-1:0]  slot_bytes_t;
	typedef logic [COUNT_W-1:0]  slot_count_t;
	typedef logic [CLASS_W-1:0]  class_idx_t;
	typedef logic [SLOT_W-1:0]   slot_idx_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MAX_SLOTS-1:0] slot_row_t;

	// Request kinds carried in the input tuser bit.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes.
	localparam status_t ST_ALLOC     = 3'd0;
	localparam status_t ST_TOO_LARGE = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_FREED     = 3'd3;
	localparam status_t ST_BAD_FREE  = 3'd4;

	// Register map: slot sizes first, then slot counts.
	localparam int REG_NUM        = 8;
	localparam int REG_ADDR_W     = 5;
	localparam int REG_BYTES_BASE = 0;
	localparam int REG_COUNT_BASE = 4;

	localparam slot_bytes_t BYTES_RESET [NUM_CLASSES] = '{17'd16, 17'd64, 17'd256, 17'd1024};
	localparam slot_count_t COUNT_RESET = 7'd64;

	// Request to the offset unit and its answer.
	typedef struct packed {
		logic       start;
		class_idx_t cls;
		slot_idx_t  slot;
	} off_req_t;

	typedef struct packed {
		logic    done;
		offset_t offset;
	} off_rsp_t;

endpackage

// ===== hw/rtl/scpa_offset.sv =====
// Offset unit: class base plus slot times size plus one, one multiply-add per cycle.
// Depends on scpa_pkg.
module scpa_offset (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scpa_pkg::slot_bytes_t slot_bytes [scpa_pkg::NUM_CLASSES],
	input  scpa_pkg::slot_count_t eff_count  [scpa_pkg::NUM_CLASSES],
	input  scpa_pkg::off_req_t   req,
	output scpa_pkg::off_rsp_t   rsp
);
	import scpa_pkg::*;

	logic                        busy_q;
	logic                        done_q;
	class_idx_t                  k_q;
	class_idx_t                  cls_q;
	slot_idx_t                   slot_q;
	offset_t                     acc_q;
	slot_count_t                 mul_b;
	logic [BYTES_W+COUNT_W-1:0]  prod;

	// Classes below the target contribute size times count; the target adds size times slot.
	always_comb begin
		mul_b = (k_q == cls_q) ? {1'b0, slot_q} : eff_count[k_q];
		prod  = slot_bytes[k_q] * mul_b;
	end

	// Step through the classes, accumulating modulo the offset width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				cls_q  <= req.cls;
				slot_q <= req.slot;
				acc_q  <= offset_t'(1);
			end else if (busy_q) begin
				acc_q <= acc_q + prod[OFFSET_W-1:0];
				if (k_q == cls_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.offset = acc_q;

endmodule

// ===== hw/rtl/size_class_pool_allocator.sv =====
// An accepted request is checked and its class row is read; an allocation then scans the row,
// one mark per cycle, from slot zero to the first free slot, and the offset unit forms the byte
// offset. Too large or bad free requests go straight from the check to the output. One request is
// in work at a time; a new one is taken while the previous result waits in the output register.
// Reset: all slots free (per-row valid flags cleared at once), registers at defaults.
// Top level of the size class pool allocator; depends on scpa_pkg and scpa_offset.
module size_class_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_bytes[19:0], free_class[21:20], free_slot[27:22], zero
	input  logic [0:0]  s_tuser,  // mode[0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // class_index[1:0], slot_index[7:2], byte_offset[31:8]
	output logic [2:0]  m_tuser,  // status[2:0]
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import scpa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_RD,
		S_SCAN,
		S_OFF,
		S_OUT
	} state_t;

	state_t      state_q;
	slot_bytes_t bytes_q [NUM_CLASSES];
	slot_count_t count_q [NUM_CLASSES];
	slot_count_t eff_count [NUM_CLASSES];

	logic        mode_q;
	logic        fit_q;
	class_idx_t  cls_q;
	slot_idx_t   slot_q;
	slot_count_t scan_q;
	slot_row_t   row_q;
	logic [NUM_CLASSES-1:0] row_valid_q;

	status_t     res_status_q;
	class_idx_t  res_cls_q;
	slot_idx_t   res_slot_q;
	offset_t     res_off_q;

	logic        m_valid_q;
	logic [31:0] m_data_q;
	status_t     m_user_q;

	// Mark memory: one row of in-use bits per class.
	slot_row_t   mem [NUM_CLASSES];
	slot_row_t   mem_rdata_s1;
	slot_row_t   row_rd;
	logic        mem_we;
	slot_row_t   mem_wdata;

	logic        fit;
	class_idx_t  fit_cls;
	logic        free_bad;
	logic [REQ_W-1:0] req_bytes;
	logic [2:0]  reg_idx;
	logic        accept;
	off_req_t    off_req;
	off_rsp_t    off_rsp;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign req_bytes = s_tdata[19:0];
	assign reg_idx   = paddr[4:2];
	assign pready    = 1'b1;

	// Slot counts above the class capacity are clamped.
	always_comb begin
		for (int k = 0; k < NUM_CLASSES; k++) begin
			eff_count[k] = (count_q[k] > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : count_q[k];
		end
	end

	// First class whose slot size exceeds the request; lowest index wins.
	always_comb begin
		fit     = 1'b0;
		fit_cls = '0;
		for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
			if (req_bytes < {{(REQ_W-BYTES_W){1'b0}}, bytes_q[k]}) begin
				fit     = 1'b1;
				fit_cls = CLASS_W'(k);
			end
		end
	end

	// A free naming a missing class or a slot at or above the count is rejected.
	assign free_bad = ({1'b0, cls_q} >= (CLASS_W+1)'(NUM_CLASSES))
		|| ({1'b0, slot_q} >= eff_count[cls_q]);

	// Rows never written read as all free.
	assign row_rd = row_valid_q[cls_q] ? mem_rdata_s1 : '0;

	// Write-back of the modified row and the offset unit start.
	always_comb begin
		mem_we        = 1'b0;
		mem_wdata     = row_q;
		off_req.start = 1'b0;
		off_req.cls   = cls_q;
		off_req.slot  = slot_q;
		unique case (state_q)
			S_RD: begin
				if (mode_q == MODE_FREE) begin
					mem_we        = 1'b1;
					mem_wdata     = row_rd & ~(slot_row_t'(1) << slot_q);
					off_req.start = 1'b1;
				end
			end
			S_SCAN: begin
				if (scan_q < eff_count[cls_q] && !row_q[scan_q[SLOT_W-1:0]]) begin
					mem_we        = 1'b1;
					mem_wdata     = row_q | (slot_row_t'(1) << scan_q[SLOT_W-1:0]);
					off_req.start = 1'b1;
					off_req.slot  = scan_q[SLOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Mark memory, registered read of the current class row.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cls_q] <= mem_wdata;
		end
		mem_rdata_s1 <= mem[cls_q];
	end

	scpa_offset u_offset (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_bytes (bytes_q),
		.eff_count  (eff_count),
		.req        (off_req),
		.rsp        (off_rsp)
	);

	// Configuration registers and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				bytes_q[k] <= BYTES_RESET[k];
				count_q[k] <= COUNT_RESET;
			end
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx < 3'(REG_COUNT_BASE)) begin
				bytes_q[reg_idx[1:0]] <= pwdata[BYTES_W-1:0];
			end else begin
				count_q[reg_idx[1:0]] <= pwdata[COUNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_idx < 3'(REG_COUNT_BASE)) begin
			prdata = {{(32-BYTES_W){1'b0}}, bytes_q[reg_idx[1:0]]};
		end else begin
			prdata = {{(32-COUNT_W){1'b0}}, count_q[reg_idx[1:0]]};
		end
	end

	// Request sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (mem_we) begin
				row_valid_q[cls_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= s_tuser[0];
						fit_q   <= fit;
						cls_q   <= (s_tuser[0] == MODE_FREE) ? s_tdata[21:20] : fit_cls;
						slot_q  <= s_tdata[27:22];
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (mode_q == MODE_ALLOC && !fit_q) begin
						res_status_q <= ST_TOO_LARGE;
						res_cls_q    <= '0;
						res_slot_q   <= '0;
						res_off_q    <= '0;
						state_q      <= S_OUT;
					end else if (mode_q == MODE_FREE && free_bad) begin
						res_status_q <= ST_BAD_FREE;
						res_cls_q    <= cls_q;
						res_slot_q   <= slot_q;
						res_off_q    <= '0;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					row_q  <= row_rd;
					scan_q <= '0;
					if (mode_q == MODE_FREE) begin
						res_status_q <= ST_FREED;
						state_q      <= S_OFF;
					end else begin
						res_status_q <= ST_ALLOC;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q >= eff_count[cls_q]) begin
						res_status_q <= ST_FULL;
						res_cls_q    <= cls_q;
						res_slot_q   <= '0;
						res_off_q    <= '0;
						state_q      <= S_OUT;
					end else if (!row_q[scan_q[SLOT_W-1:0]]) begin
						slot_q  <= scan_q[SLOT_W-1:0];
						state_q <= S_OFF;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_OFF: begin
					if (off_rsp.done) begin
						res_cls_q  <= cls_q;
						res_slot_q <= slot_q;
						res_off_q  <= off_rsp.offset;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_data_q  <= {res_off_q, res_slot_q, res_cls_q};
						m_user_q  <= res_status_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

// ===== hw/rtl/scpa_checker.sv =====
// Port-level checks for the size class pool allocator, bound to the top level.
// Depends on scpa_pkg and size_class_pool_allocator.
module scpa_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        pready
);
	import scpa_pkg::*;

	// A stalled result beat holds its content.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Only defined status codes leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_BAD_FREE)
		else $error("undefined status code");

	// An oversized request reports no class, slot or offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_TOO_LARGE |-> m_tdata == 32'd0)
		else $error("too large result carries data");

	// A full class or a bad free reports no offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_BAD_FREE) |-> m_tdata[31:8] == 24'd0)
		else $error("full or bad free result carries an offset");

	// The configuration port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port stalled");

endmodule

bind size_class_pool_allocator scpa_port_checks u_scpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);
